### sv/morse_symbol_keyer_assert.svh
// Assertion macros for the Morse symbol keyer.
// Included by the top level only; no other dependencies.
`ifndef MORSE_SYMBOL_KEYER_ASSERT_SVH
`define MORSE_SYMBOL_KEYER_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define MSK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyer check failed");

// Next-cycle implication, checked only out of reset.
`define MSK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyer check failed");

`endif

### sv/msk_pkg.sv
// Shared types and constants for the Morse symbol keyer.
// No dependencies; imported by every keyer module.
`timescale 1ns / 1ps

package msk_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int POS_W       = $clog2(STORE_DEPTH);
    localparam int LEN_W       = POS_W + 1;
    localparam int NUM_BANKS   = 2;
    localparam int BANK_DEPTH  = STORE_DEPTH / NUM_BANKS;
    localparam int BANK_AW     = POS_W - 1;

    localparam int DIT_W       = 12;
    localparam int TICK_W      = 16;
    localparam int PLAY_W      = 8;
    localparam logic [DIT_W-1:0] DIT_RESET = 12'd100;

    typedef enum logic [2:0] {
        CODE_DOT        = 3'd0,
        CODE_DASH       = 3'd1,
        CODE_LETTER_GAP = 3'd2,
        CODE_WORD_GAP   = 3'd3,
        CODE_END        = 3'd4
    } t_code;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_LOAD = 2'd1,
        REQ_RUN  = 2'd2
    } t_req;

    // Up to two writes per load: the symbol and the end mark at the next slot.
    // Consecutive slots always land in different banks.
    typedef struct packed {
        logic             sym_we;
        logic [POS_W-1:0] sym_addr;
        t_code            sym_code;
        logic             end_we;
        logic [POS_W-1:0] end_addr;
    } t_store_wr;

    typedef struct packed {
        logic [PLAY_W-1:0] play_position;
        logic              message_pending;
        logic              led_on;
    } t_result;

endpackage

### sv/msk_store.sv
// Symbol store: two interleaved single-port-write banks with a registered read.
// Depends on msk_pkg. Forwards a same-cycle write to the read data.
`timescale 1ns / 1ps

module msk_store (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  msk_pkg::t_store_wr      i_wr,
    input  logic [msk_pkg::POS_W-1:0] i_rd_addr,
    output msk_pkg::t_code          o_rd_code
);
    import msk_pkg::*;

    t_code bank_q [NUM_BANKS];
    logic  r_sel;

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        t_code              mem [BANK_DEPTH];
        logic               we;
        logic [BANK_AW-1:0] widx;
        logic [BANK_AW-1:0] ridx;
        t_code              wdata;
        t_code              r_q;
        t_code              r_wd;
        logic               r_hit;

        assign ridx = i_rd_addr[POS_W-1:1];

        always_comb begin
            we    = 1'b0;
            widx  = i_wr.sym_addr[POS_W-1:1];
            wdata = i_wr.sym_code;
            if (i_wr.sym_we && (i_wr.sym_addr[0] == 1'(b))) begin
                we = 1'b1;
            end else if (i_wr.end_we && (i_wr.end_addr[0] == 1'(b))) begin
                we    = 1'b1;
                widx  = i_wr.end_addr[POS_W-1:1];
                wdata = CODE_END;
            end
        end

        always_ff @(posedge i_clk) begin
            if (we) begin
                mem[widx] <= wdata;
            end
            r_q  <= mem[ridx];
            r_wd <= wdata;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_hit <= 1'b0;
            end else begin
                r_hit <= we && (widx == ridx);
            end
        end

        assign bank_q[b] = r_hit ? r_wd : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else begin
            r_sel <= i_rd_addr[0];
        end
    end

    assign o_rd_code = bank_q[r_sel];

endmodule

### sv/msk_ctrl.sv
// Keyer control: phase, timing, positions and the dit register.
// Depends on msk_pkg. Reads the entry at the play position from msk_store.
`timescale 1ns / 1ps

module msk_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [msk_pkg::DIT_W-1:0]   i_cfg_wr_data,
    input  logic                        i_accept,
    input  logic [1:0]                  i_req_type,
    input  logic [1:0]                  i_symbol,
    input  logic                        i_first,
    input  logic                        i_last,
    input  logic                        i_run_enable,
    input  msk_pkg::t_code              i_code,
    output msk_pkg::t_store_wr          o_wr,
    output logic [msk_pkg::POS_W-1:0]   o_rd_addr,
    output msk_pkg::t_result            o_result
);
    import msk_pkg::*;

    typedef enum logic [1:0] {
        PH_CHOOSE = 2'd0,
        PH_MARK   = 2'd1,
        PH_GAP    = 2'd2
    } t_phase;

    t_phase             r_phase,   n_phase;
    logic [TICK_W-1:0]  r_elapsed, n_elapsed;
    logic [TICK_W-1:0]  r_period,  n_period;
    logic [POS_W-1:0]   r_rp,      n_rp;
    logic [LEN_W-1:0]   r_len,     n_len;
    logic               r_frozen,  n_frozen;
    logic [DIT_W-1:0]   r_dit;

    logic [TICK_W-1:0]  dit1, dit3, dit7;
    logic [TICK_W-1:0]  elapsed_inc;
    logic [LEN_W-1:0]   len_base, len_mid, len_fin;

    assign dit1 = TICK_W'(r_dit);
    assign dit3 = dit1 + (dit1 << 1);
    assign dit7 = (dit1 << 3) - dit1;
    assign elapsed_inc = (r_elapsed != '1) ? r_elapsed + 1'b1 : r_elapsed;

    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_period  = r_period;
        n_rp      = r_rp;
        n_len     = r_len;
        n_frozen  = r_frozen;
        o_wr      = '0;
        len_base  = i_first ? '0 : r_len;
        len_mid   = len_base;
        len_fin   = len_base;

        if (i_accept) begin
            case (t_req'(i_req_type))
                REQ_TICK: begin
                    if (!r_frozen) begin
                        if (r_phase == PH_CHOOSE) begin
                            if ({1'b0, r_rp} < r_len) begin
                                case (i_code)
                                    CODE_DASH: begin
                                        n_phase = PH_MARK; n_period = dit3; n_elapsed = '0;
                                    end
                                    CODE_DOT: begin
                                        n_phase = PH_MARK; n_period = dit1; n_elapsed = '0;
                                    end
                                    CODE_LETTER_GAP: begin
                                        n_phase = PH_GAP; n_period = dit3; n_elapsed = '0;
                                    end
                                    CODE_WORD_GAP: begin
                                        n_phase = PH_GAP; n_period = dit7; n_elapsed = '0;
                                    end
                                    default: begin
                                        // end mark: message done, drop it
                                        n_len = '0;
                                        n_rp  = '0;
                                    end
                                endcase
                            end
                        end else begin
                            n_elapsed = elapsed_inc;
                            if (elapsed_inc > r_period) begin
                                if (r_phase == PH_MARK) begin
                                    n_phase   = PH_GAP;
                                    n_period  = dit1;
                                    n_elapsed = '0;
                                end else begin
                                    n_rp    = r_rp + 1'b1;
                                    n_phase = PH_CHOOSE;
                                end
                            end
                        end
                    end
                end
                REQ_LOAD: begin
                    if (i_first) begin
                        n_rp      = '0;
                        n_phase   = PH_CHOOSE;
                        n_elapsed = '0;
                    end
                    // last slot is reserved for the end mark
                    if (len_base < LEN_W'(STORE_DEPTH - 1)) begin
                        o_wr.sym_we   = 1'b1;
                        o_wr.sym_addr = len_base[POS_W-1:0];
                        o_wr.sym_code = t_code'({1'b0, i_symbol});
                        len_mid       = len_base + 1'b1;
                    end
                    len_fin = len_mid;
                    if (i_last && (len_mid < LEN_W'(STORE_DEPTH))) begin
                        o_wr.end_we   = 1'b1;
                        o_wr.end_addr = len_mid[POS_W-1:0];
                        len_fin       = len_mid + 1'b1;
                    end
                    n_len = len_fin;
                end
                REQ_RUN: begin
                    n_frozen = !i_run_enable;
                end
                default: begin
                end
            endcase
        end
    end

    // Read ahead at the next play position so the entry is ready next cycle.
    assign o_rd_addr = n_rp;

    assign o_result.led_on          = (n_phase == PH_MARK);
    assign o_result.message_pending = ({1'b0, n_rp} < n_len);
    assign o_result.play_position   = PLAY_W'(n_rp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_CHOOSE;
            r_elapsed <= '0;
            r_period  <= '0;
            r_rp      <= '0;
            r_len     <= '0;
            r_frozen  <= 1'b0;
            r_dit     <= DIT_RESET;
        end else begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_period  <= n_period;
            r_rp      <= n_rp;
            r_len     <= n_len;
            r_frozen  <= n_frozen;
            if (i_cfg_wr_en) begin
                r_dit <= i_cfg_wr_data;
            end
        end
    end

endmodule

### sv/morse_symbol_keyer.sv
// Morse symbol keyer top level: stream ports, output register, assertions.
// Depends on msk_pkg, msk_ctrl, msk_store and morse_symbol_keyer_assert.svh.
//
//   channel   dir  handshake                       payload
//   s_axis    in   s_axis_tvalid / s_axis_tready   tdata, tuser, tlast
//   m_axis    out  m_axis_tvalid / m_axis_tready   tdata
//   cfg       in   i_cfg_wr_en                     i_cfg_wr_data (dit length)
//
// One request per cycle unless a result is stalled, one result per request, registered
// in the cycle after acceptance. The store is read every cycle at the next play position; a write in the same
// cycle is forwarded, so a tick can follow a load directly.
// A stalled result holds s_axis_tready low; a taken result frees the slot the
// same cycle. Reset is synchronous; the store needs no clearing.
`timescale 1ns / 1ps

`include "morse_symbol_keyer_assert.svh"

module morse_symbol_keyer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [11:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [1:0] symbol, [2] run_enable
    input  logic [2:0]  s_axis_tuser,   // [1:0] req_type, [2] first_symbol
    input  logic        s_axis_tlast,   // last_symbol
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] led_on, [1] message_pending, [9:2] play_position
);
    import msk_pkg::*;

    logic              accept;
    t_store_wr         wr;
    logic [POS_W-1:0]  rd_addr;
    t_code             rd_code;
    t_result           result;
    logic              r_out_valid;
    t_result           r_out_data;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    msk_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_accept     (accept),
        .i_req_type   (s_axis_tuser[1:0]),
        .i_symbol     (s_axis_tdata[1:0]),
        .i_first      (s_axis_tuser[2]),
        .i_last       (s_axis_tlast),
        .i_run_enable (s_axis_tdata[2]),
        .i_code       (rd_code),
        .o_wr         (wr),
        .o_rd_addr    (rd_addr),
        .o_result     (result)
    );

    msk_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_rd_addr(rd_addr),
        .o_rd_code(rd_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 16'({r_out_data.play_position,
                                r_out_data.message_pending,
                                r_out_data.led_on});

    // every request yields a result in the next cycle
    `MSK_ASSERT_NXT(a_req_gives_result, i_clk, i_rst_n, accept, m_axis_tvalid)
    // a result waiting on the sink blocks new requests
    `MSK_ASSERT_IMP(a_stall_blocks_input, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    // a mark only sounds while the message still has symbols left
    `MSK_ASSERT_IMP(a_mark_implies_pending, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1])

endmodule

### tb/sv/tb_morse_symbol_keyer.sv
`timescale 1ns / 1ps
// Self-checking testbench for morse_symbol_keyer: directed table, then random requests.
// Depends on msk_pkg and the keyer RTL; each result is checked against a local keyer model or a row's given result.

module tb_morse_symbol_keyer;
    import msk_pkg::*;

    localparam int          CLK_PERIOD  = 20;
    localparam int          HOLD_CYCLES = 400;
    localparam int          PRINT_LIMIT = 40;
    localparam logic [1:0]  REQ_UNKNOWN = 2'd3;
    localparam int          NUM_PHASES  = 7;

    typedef enum logic [1:0] {
        KP_CHOOSE = 2'd0,
        KP_MARK   = 2'd1,
        KP_GAP    = 2'd2
    } t_keyer_phase;

    typedef struct {
        logic [1:0] req;
        logic [1:0] sym;
        logic       first;
        logic       last;
        logic       run;
    } t_keyer_req;

    typedef struct {
        t_keyer_req item;
        int         reps;
        bit         typed;
        t_result    res;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [11:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [1:0] symbol, [2] run_enable
    logic [2:0]  s_axis_tuser = '0;   // [1:0] req_type, [2] first_symbol
    logic        s_axis_tlast = 1'b0; // last_symbol
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [0] led_on, [1] message_pending, [9:2] play_position

    morse_symbol_keyer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // keyer model state
    logic [11:0]         kp_dit;
    t_keyer_phase        kp_phase;
    logic [15:0]         kp_elapsed;
    logic [15:0]         kp_period;
    int                  kp_pos;
    int                  kp_len;
    t_code               kp_store [STORE_DEPTH];
    bit                  kp_frozen;

    t_result             expected_results [$];
    t_stim_row           stim_rows [$];
    int                  err_count = 0;
    int                  results_seen = 0;

    int unsigned         idle_pct = 0;
    int unsigned         stall_pct = 0;
    int                  hold_requests = 0;
    int                  hold_seen = 0;
    int                  hold_left = 0;

    int                  phase_dit   [NUM_PHASES] = '{1, 3, 4095, 0, 2, 100, 5};
    int unsigned         phase_idle  [NUM_PHASES] = '{0, 58, 0, 24, 0, 58, 24};
    int unsigned         phase_stall [NUM_PHASES] = '{0, 0, 58, 24, 0, 0, 24};
    int                  phase_items [NUM_PHASES] = '{120, 120, 120, 120, 160, 100, 110};
    localparam int       PRESSURE_PHASE = 4;

    function automatic void enter_keyer_phase(t_keyer_phase next, int unsigned period);
        kp_phase   = next;
        kp_period  = period[15:0];
        kp_elapsed = '0;
    endfunction

    function automatic t_result next_keyer_output(t_keyer_req r);
        t_result res;
        if (r.req == REQ_TICK) begin
            if (!kp_frozen) begin
                if (kp_phase == KP_CHOOSE) begin
                    if (kp_pos < kp_len && kp_pos < STORE_DEPTH) begin
                        case (kp_store[kp_pos])
                            CODE_DASH:       enter_keyer_phase(KP_MARK, 3 * kp_dit);
                            CODE_DOT:        enter_keyer_phase(KP_MARK, kp_dit);
                            CODE_LETTER_GAP: enter_keyer_phase(KP_GAP, 3 * kp_dit);
                            CODE_WORD_GAP:   enter_keyer_phase(KP_GAP, 7 * kp_dit);
                            default: begin
                                // end mark: message consumed
                                kp_len = 0;
                                kp_pos = 0;
                            end
                        endcase
                    end
                end else begin
                    if (kp_elapsed != 16'hFFFF) kp_elapsed = kp_elapsed + 16'd1;
                    if (kp_elapsed > kp_period) begin
                        if (kp_phase == KP_MARK) begin
                            enter_keyer_phase(KP_GAP, kp_dit);
                        end else begin
                            kp_pos   = kp_pos + 1;
                            kp_phase = KP_CHOOSE;
                        end
                    end
                end
            end
        end else if (r.req == REQ_LOAD) begin
            if (r.first) begin
                kp_len     = 0;
                kp_pos     = 0;
                kp_phase   = KP_CHOOSE;
                kp_elapsed = '0;
            end
            // last slot is reserved for the end mark
            if (kp_len < STORE_DEPTH - 1) begin
                kp_store[kp_len] = t_code'({1'b0, r.sym});
                kp_len = kp_len + 1;
            end
            if (r.last && kp_len < STORE_DEPTH) begin
                kp_store[kp_len] = CODE_END;
                kp_len = kp_len + 1;
            end
        end else if (r.req == REQ_RUN) begin
            kp_frozen = !r.run;
        end
        res.led_on          = (kp_phase == KP_MARK);
        res.message_pending = (kp_pos < kp_len);
        res.play_position   = kp_pos[7:0];
        return res;
    endfunction

    function automatic t_keyer_req random_request();
        t_keyer_req  r;
        int unsigned roll;
        roll    = $urandom_range(99);
        r.sym   = 2'($urandom_range(3));
        r.first = 1'($urandom_range(1));
        r.last  = 1'($urandom_range(1));
        r.run   = 1'($urandom_range(1));
        if (roll < 3) begin
            r.req = REQ_UNKNOWN;
        end else if (roll < 8) begin
            r.req = REQ_RUN;
            r.run = ($urandom_range(9) < 7);
        end else if (roll < 28) begin
            r.req   = REQ_LOAD;
            r.first = ($urandom_range(15) == 0);
            r.last  = ($urandom_range(4) == 0);
        end else begin
            r.req = REQ_TICK;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
        if (err_count < PRINT_LIMIT)
            $display("%0t: result %0d %s got %0h want %0h", $realtime, results_seen, field,
                     got, want);
        err_count++;
    endtask

    task automatic add_row(logic [1:0] req, logic [1:0] sym, logic first, logic last,
                           logic run, int reps, bit typed = 1'b0, t_result res = '0);
        t_stim_row row;
        row.item.req   = req;
        row.item.sym   = sym;
        row.item.first = first;
        row.item.last  = last;
        row.item.run   = run;
        row.reps       = reps;
        row.typed      = typed;
        row.res        = res;
        stim_rows.push_back(row);
    endtask

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(t_keyer_req r, bit typed, t_result res);
        t_result want;
        if ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, r.run, r.sym};
        s_axis_tuser  <= {r.first, r.req};
        s_axis_tlast  <= r.last;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        want = next_keyer_output(r);
        expected_results.push_back(typed ? res : want);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_dit(int value);
        wait_results_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value[11:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        kp_dit = value[11:0];
    endtask

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[9:0]);
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[7:0], 8'h00);
            end else begin
                want = expected_results.pop_front();
                if (got.led_on !== want.led_on)
                    report_mismatch("led_on", 8'(got.led_on), 8'(want.led_on));
                if (got.message_pending !== want.message_pending)
                    report_mismatch("message_pending", 8'(got.message_pending),
                                    8'(want.message_pending));
                if (got.play_position !== want.play_position)
                    report_mismatch("play_position", got.play_position, want.play_position);
            end
            results_seen++;
        end
    end

    initial begin
        #10_000_000;
        $display("[morse_symbol_keyer] ERROR");
        $finish;
    end

    initial begin : stimulus
        t_keyer_req r;
        t_result    idle_res;
        t_result    fresh_res;
        int         sent;
        int         overfill_row;

        idle_res  = '0;
        fresh_res = '0;
        fresh_res.message_pending = 1'b1;

        kp_dit     = DIT_RESET;
        kp_phase   = KP_CHOOSE;
        kp_elapsed = '0;
        kp_period  = '0;
        kp_pos     = 0;
        kp_len     = 0;
        kp_frozen  = 1'b0;

        add_row(REQ_TICK, CODE_DOT[1:0], 0, 0, 0, 1, 1'b1, idle_res);
        add_row(REQ_UNKNOWN, CODE_WORD_GAP[1:0], 1, 1, 1, 1, 1'b1, idle_res);
        add_row(REQ_RUN, CODE_DOT[1:0], 0, 0, 0, 1, 1'b1, idle_res);
        add_row(REQ_TICK, CODE_DOT[1:0], 0, 0, 0, 1, 1'b1, idle_res);
        add_row(REQ_RUN, CODE_DOT[1:0], 0, 0, 1, 1, 1'b1, idle_res);
        // one-symbol message
        add_row(REQ_LOAD, CODE_DOT[1:0], 1, 1, 0, 1, 1'b1, fresh_res);
        add_row(REQ_TICK, CODE_DOT[1:0], 0, 0, 0, 12);
        add_row(REQ_LOAD, CODE_DASH[1:0], 1, 0, 0, 1);
        add_row(REQ_LOAD, CODE_LETTER_GAP[1:0], 0, 0, 0, 1);
        add_row(REQ_LOAD, CODE_WORD_GAP[1:0], 0, 0, 0, 1);
        add_row(REQ_LOAD, CODE_DOT[1:0], 0, 1, 0, 1);
        add_row(REQ_TICK, CODE_DASH[1:0], 1, 1, 1, 8);
        // restart while playing
        add_row(REQ_LOAD, CODE_DASH[1:0], 1, 1, 0, 1, 1'b1, fresh_res);
        add_row(REQ_TICK, CODE_DOT[1:0], 0, 0, 0, 3);
        // freeze mid-mark; loads still land
        add_row(REQ_RUN, CODE_DOT[1:0], 0, 0, 0, 1);
        add_row(REQ_TICK, CODE_DOT[1:0], 0, 0, 0, 4);
        add_row(REQ_LOAD, CODE_DOT[1:0], 0, 0, 0, 1);
        add_row(REQ_RUN, CODE_DOT[1:0], 0, 0, 1, 1);
        add_row(REQ_TICK, CODE_DOT[1:0], 0, 0, 0, 40);
        // overfill the store, then play it out to position 255 and the end mark;
        // zero dit length here, so each gap takes two ticks
        overfill_row = stim_rows.size();
        add_row(REQ_LOAD, CODE_LETTER_GAP[1:0], 1, 0, 0, 1);
        add_row(REQ_LOAD, CODE_LETTER_GAP[1:0], 0, 0, 0, 260);
        add_row(REQ_LOAD, CODE_WORD_GAP[1:0], 0, 1, 0, 1);
        add_row(REQ_TICK, CODE_DOT[1:0], 0, 0, 0, 520);
        add_row(REQ_TICK, CODE_DOT[1:0], 0, 0, 0, 1, 1'b1, idle_res);
        add_row(REQ_LOAD, CODE_WORD_GAP[1:0], 1, 1, 0, 1, 1'b1, fresh_res);
        add_row(REQ_TICK, CODE_DOT[1:0], 0, 0, 0, 30);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_dit(1);

        foreach (stim_rows[i]) begin
            if (i == overfill_row) write_dit(0);
            repeat (stim_rows[i].reps)
                send_request(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].res);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_dit(phase_dit[p]);
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            if (p == PRESSURE_PHASE) hold_requests++;
            sent = 0;
            while (sent < phase_items[p]) begin
                r = random_request();
                send_request(r, 1'b0, idle_res);
                if (r.req != REQ_UNKNOWN) sent++;
            end
        end

        wait_results_drained();
        repeat (16) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("missing results", 8'(expected_results.size()), 8'h00);

        if (err_count == 0) begin
            $display("[morse_symbol_keyer] OK");
        end else begin
            $display("[morse_symbol_keyer] ERROR");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/msk_pkg.sv
sv/msk_store.sv
sv/msk_ctrl.sv
sv/morse_symbol_keyer.sv
tb/sv/tb_morse_symbol_keyer.sv
